>>> rtl/rmmd_pkg.sv
// ============================================================================
// Range max Manhattan distance package
// Shared constants, types and state codes for the range max distance core.
// ============================================================================
`default_nettype none

package rmmd_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int MAX_DIMS    = 5;
    localparam int COORD_WIDTH = 21;

    localparam int MASK_SLOTS = 2 ** MAX_DIMS;
    localparam int MASK_W     = (MASK_SLOTS > 2) ? $clog2(MASK_SLOTS) : 1;
    localparam int NODE_SLOTS = 4 * MAX_POINTS;
    localparam int NODE_W     = $clog2(NODE_SLOTS);
    localparam int IDX_W      = 11;
    localparam int POS_W      = (IDX_W > $clog2(MAX_POINTS + 1)) ? IDX_W
                                                                 : $clog2(MAX_POINTS + 1);
    localparam int DIMS_W     = 3;
    localparam int SUM_W      = COORD_WIDTH + $clog2(MAX_DIMS + 1);
    localparam int DIFF_W     = SUM_W + 1;
    localparam int DIST_W     = 24;
    localparam int TREE_LEVELS = $clog2(MAX_POINTS) + 2;
    localparam int SP_W       = $clog2(TREE_LEVELS + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_DIMS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef sum_t [MASK_SLOTS-1:0] sums_t;

    typedef struct packed {
        sums_t mx;
        sums_t mn;
    } row_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DESC,
        S_LRD,
        S_LWR,
        S_SRD,
        S_PRD,
        S_PWR,
        S_QVISIT,
        S_QACC,
        S_FIN,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

>>> rtl/rmmd_ram.sv
// ============================================================================
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ============================================================================
`default_nettype none

module rmmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> rtl/range_max_manhattan_distance_core.sv
// ============================================================================
// Range max Manhattan distance core
// Segment tree of per-mask max and min coordinate sums over a point table.
// ============================================================================
// A write item replaces one point and updates its root-to-leaf path; a query
// item returns the largest Manhattan distance inside an index range. All node
// data sits in one single-port RAM row per tree node (all 32 masks side by
// side), and that port sets the rate: a write descends to the leaf, rewrites
// it, then at each level reads the sibling and parent and writes the parent;
// a query visits nodes and reads each covered one, then scans the active masks.
// After reset a clearing pass zeroes all 4096 RAM rows before the first
// item is taken.
`default_nettype none

module range_max_manhattan_distance_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [rmmd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [rmmd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  func,
    input  wire logic [rmmd_pkg::IDX_W-1:0]            point_index,
    input  wire logic signed [rmmd_pkg::COORD_WIDTH-1:0] coord_0,
    input  wire logic signed [rmmd_pkg::COORD_WIDTH-1:0] coord_1,
    input  wire logic signed [rmmd_pkg::COORD_WIDTH-1:0] coord_2,
    input  wire logic signed [rmmd_pkg::COORD_WIDTH-1:0] coord_3,
    input  wire logic signed [rmmd_pkg::COORD_WIDTH-1:0] coord_4,
    input  wire logic [rmmd_pkg::IDX_W-1:0]            range_first,
    input  wire logic [rmmd_pkg::IDX_W-1:0]            range_last,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [rmmd_pkg::DIST_W-1:0]                max_distance,
    output logic                                       status
);

    import rmmd_pkg::*;

    localparam logic [DIFF_W-1:0] DIST_SAT = DIFF_W'((64'd1 << DIST_W) - 64'd1);

    state_t state_reg, state_next;

    logic [DIMS_W-1:0]      dims_reg;
    logic [CFG_DATA_W-1:0]  count_reg;
    logic [DIMS_W-1:0]      dims_eff;
    logic [POS_W-1:0]       n_eff;
    logic [MASK_W:0]        mask_cnt;
    logic [MASK_W-1:0]      mask_last;

    logic [NODE_W-1:0]      clr_reg, clr_next;
    logic [NODE_W-1:0]      node_reg, node_next;
    logic [POS_W-1:0]       lo_reg, lo_next;
    logic [POS_W-1:0]       hi_reg, hi_next;
    logic [POS_W-1:0]       idx_reg, idx_next;
    logic [POS_W-1:0]       qf_reg, qf_next;
    logic [POS_W-1:0]       ql_reg, ql_next;
    logic signed [COORD_WIDTH-1:0] crd_reg [MAX_DIMS];
    logic signed [COORD_WIDTH-1:0] crd_in [5];

    logic [NODE_W-1:0]      stk_node_reg [TREE_LEVELS];
    logic [POS_W-1:0]       stk_lo_reg [TREE_LEVELS];
    logic [POS_W-1:0]       stk_hi_reg [TREE_LEVELS];
    logic [SP_W-1:0]        sp_reg, sp_next;
    logic                   push;

    row_t                   cur_row_reg, cur_row_next;
    row_t                   sib_row_reg, sib_row_next;
    sums_t                  acc_max_reg, acc_max_next;
    sums_t                  acc_min_reg, acc_min_next;
    sums_t                  leaf_sums;
    logic [MASK_W-1:0]      m_reg, m_next;
    logic [DIFF_W-1:0]      best_reg, best_next;
    logic                   res_status_reg, res_status_next;

    logic                   out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]      dist_reg, dist_next;
    logic                   status_reg, status_next;

    logic                   ram_we;
    logic [NODE_W-1:0]      ram_addr;
    row_t                   ram_wdata;
    row_t                   ram_rdata;

    logic [POS_W:0]         mid_sum;
    logic [POS_W-1:0]       mid;
    logic                   accept;
    logic [POS_W-1:0]       in_idx, in_qf, in_ql;
    logic signed [DIFF_W-1:0] diff;

    rmmd_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (NODE_SLOTS)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign crd_in[0] = coord_0;
    assign crd_in[1] = coord_1;
    assign crd_in[2] = coord_2;
    assign crd_in[3] = coord_3;
    assign crd_in[4] = coord_4;

    always_comb
    begin
        if (dims_reg == '0)
        begin
            dims_eff = DIMS_W'(1);
        end
        else if (dims_reg > DIMS_W'(MAX_DIMS))
        begin
            dims_eff = DIMS_W'(MAX_DIMS);
        end
        else
        begin
            dims_eff = dims_reg;
        end
        if (count_reg == '0)
        begin
            n_eff = POS_W'(1);
        end
        else if (POS_W'(count_reg) > POS_W'(MAX_POINTS))
        begin
            n_eff = POS_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = POS_W'(count_reg);
        end
        mask_cnt  = (MASK_W + 1)'(1) << dims_eff;
        mask_last = MASK_W'(mask_cnt - (MASK_W + 1)'(1));
    end

    always_comb
    begin
        for (int m = 0; m < MASK_SLOTS; m++)
        begin
            leaf_sums[m] = '0;
            for (int j = 0; j < MAX_DIMS; j++)
            begin
                if (DIMS_W'(j) < dims_eff)
                begin
                    if (m[j])
                    begin
                        leaf_sums[m] = leaf_sums[m] + SUM_W'(crd_reg[j]);
                    end
                    else
                    begin
                        leaf_sums[m] = leaf_sums[m] - SUM_W'(crd_reg[j]);
                    end
                end
            end
        end
    end

    assign mid_sum  = (POS_W + 1)'(lo_reg) + (POS_W + 1)'(hi_reg);
    assign mid      = mid_sum[POS_W:1];
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign in_idx   = POS_W'(point_index);
    assign in_qf    = POS_W'(range_first);
    assign in_ql    = POS_W'(range_last);
    assign diff     = DIFF_W'(acc_max_reg[m_reg]) - DIFF_W'(acc_min_reg[m_reg]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == NODE_W'(NODE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_WRITE)
                    begin
                        if (in_idx != '0 && in_idx <= n_eff)
                        begin
                            state_next = S_DESC;
                        end
                    end
                    else if (in_qf == '0 || in_ql > n_eff || in_qf > in_ql)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_QVISIT;
                    end
                end
            end
            S_DESC:
            begin
                if (lo_reg == hi_reg)
                begin
                    state_next = S_LRD;
                end
            end
            S_LRD:    state_next = S_LWR;
            S_LWR:    state_next = (node_reg == NODE_W'(1)) ? S_IDLE : S_SRD;
            S_SRD:    state_next = S_PRD;
            S_PRD:    state_next = S_PWR;
            S_PWR:    state_next = (node_reg == NODE_W'(1)) ? S_IDLE : S_SRD;
            S_QVISIT:
            begin
                if (qf_reg <= lo_reg && hi_reg <= ql_reg)
                begin
                    state_next = S_QACC;
                end
                else if (!(qf_reg <= mid) && !(ql_reg > mid) && sp_reg == '0)
                begin
                    state_next = S_FIN;
                end
            end
            S_QACC:   state_next = (sp_reg == '0) ? S_FIN : S_QVISIT;
            S_FIN:    state_next = (m_reg == mask_last) ? S_OUT : S_FIN;
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        clr_next        = clr_reg;
        node_next       = node_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        idx_next        = idx_reg;
        qf_next         = qf_reg;
        ql_next         = ql_reg;
        sp_next         = sp_reg;
        push            = 1'b0;
        cur_row_next    = cur_row_reg;
        sib_row_next    = sib_row_reg;
        acc_max_next    = acc_max_reg;
        acc_min_next    = acc_min_reg;
        m_next          = m_reg;
        best_next       = best_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        dist_next       = dist_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_addr        = node_reg;
        ram_wdata       = cur_row_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + NODE_W'(1);
            end
            S_IDLE:
            begin
                node_next = NODE_W'(1);
                lo_next   = POS_W'(1);
                hi_next   = n_eff;
                idx_next  = in_idx;
                qf_next   = in_qf;
                ql_next   = in_ql;
                sp_next   = '0;
                m_next    = '0;
                best_next = '0;
                for (int m = 0; m < MASK_SLOTS; m++)
                begin
                    acc_max_next[m] = {1'b1, {(SUM_W - 1){1'b0}}};
                    acc_min_next[m] = {1'b0, {(SUM_W - 1){1'b1}}};
                end
                res_status_next = (in_qf == '0 || in_ql > n_eff || in_qf > in_ql)
                                  ? STATUS_BAD : STATUS_OK;
            end
            S_DESC:
            begin
                if (lo_reg != hi_reg)
                begin
                    if (idx_reg <= mid)
                    begin
                        node_next = {node_reg[NODE_W-2:0], 1'b0};
                        hi_next   = mid;
                    end
                    else
                    begin
                        node_next = {node_reg[NODE_W-2:0], 1'b1};
                        lo_next   = mid + POS_W'(1);
                    end
                end
            end
            S_LRD:
            begin
                ram_addr = node_reg;
            end
            S_LWR:
            begin
                cur_row_next = ram_rdata;
                for (int m = 0; m < MASK_SLOTS; m++)
                begin
                    if ((MASK_W + 1)'(m) < mask_cnt)
                    begin
                        cur_row_next.mx[m] = leaf_sums[m];
                        cur_row_next.mn[m] = leaf_sums[m];
                    end
                end
                ram_we    = 1'b1;
                ram_addr  = node_reg;
                ram_wdata = cur_row_next;
            end
            S_SRD:
            begin
                ram_addr = node_reg ^ NODE_W'(1);
            end
            S_PRD:
            begin
                ram_addr     = node_reg >> 1;
                sib_row_next = ram_rdata;
                node_next    = node_reg >> 1;
            end
            S_PWR:
            begin
                cur_row_next = ram_rdata;
                for (int m = 0; m < MASK_SLOTS; m++)
                begin
                    if ((MASK_W + 1)'(m) < mask_cnt)
                    begin
                        cur_row_next.mx[m] = (cur_row_reg.mx[m] > sib_row_reg.mx[m])
                                             ? cur_row_reg.mx[m] : sib_row_reg.mx[m];
                        cur_row_next.mn[m] = (cur_row_reg.mn[m] < sib_row_reg.mn[m])
                                             ? cur_row_reg.mn[m] : sib_row_reg.mn[m];
                    end
                end
                ram_we    = 1'b1;
                ram_addr  = node_reg;
                ram_wdata = cur_row_next;
            end
            S_QVISIT:
            begin
                ram_addr = node_reg;
                if (!(qf_reg <= lo_reg && hi_reg <= ql_reg))
                begin
                    if (qf_reg <= mid)
                    begin
                        node_next = {node_reg[NODE_W-2:0], 1'b0};
                        hi_next   = mid;
                        if (ql_reg > mid)
                        begin
                            push    = 1'b1;
                            sp_next = sp_reg + SP_W'(1);
                        end
                    end
                    else if (ql_reg > mid)
                    begin
                        node_next = {node_reg[NODE_W-2:0], 1'b1};
                        lo_next   = mid + POS_W'(1);
                    end
                    else if (sp_reg != '0)
                    begin
                        sp_next   = sp_reg - SP_W'(1);
                        node_next = stk_node_reg[sp_next];
                        lo_next   = stk_lo_reg[sp_next];
                        hi_next   = stk_hi_reg[sp_next];
                    end
                end
            end
            S_QACC:
            begin
                for (int m = 0; m < MASK_SLOTS; m++)
                begin
                    if ((MASK_W + 1)'(m) < mask_cnt)
                    begin
                        if (ram_rdata.mx[m] > acc_max_reg[m])
                        begin
                            acc_max_next[m] = ram_rdata.mx[m];
                        end
                        if (ram_rdata.mn[m] < acc_min_reg[m])
                        begin
                            acc_min_next[m] = ram_rdata.mn[m];
                        end
                    end
                end
                if (sp_reg != '0)
                begin
                    sp_next   = sp_reg - SP_W'(1);
                    node_next = stk_node_reg[sp_next];
                    lo_next   = stk_lo_reg[sp_next];
                    hi_next   = stk_hi_reg[sp_next];
                end
            end
            S_FIN:
            begin
                if (diff > $signed(best_reg))
                begin
                    best_next = (diff > $signed(DIST_SAT)) ? DIST_SAT : DIFF_W'(diff);
                end
                m_next = m_reg + MASK_W'(1);
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    dist_next      = DIST_W'(best_reg);
                    status_next    = res_status_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
            dims_reg      <= DIMS_W'(MAX_DIMS);
            count_reg     <= CFG_DATA_W'(MAX_POINTS);
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DIMS:  dims_reg  <= DIMS_W'(cfg_data);
                    REG_COUNT: count_reg <= cfg_data;
                    default:   dims_reg  <= dims_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        idx_reg        <= idx_next;
        qf_reg         <= qf_next;
        ql_reg         <= ql_next;
        cur_row_reg    <= cur_row_next;
        sib_row_reg    <= sib_row_next;
        acc_max_reg    <= acc_max_next;
        acc_min_reg    <= acc_min_next;
        m_reg          <= m_next;
        best_reg       <= best_next;
        res_status_reg <= res_status_next;
        dist_reg       <= dist_next;
        status_reg     <= status_next;
        if (accept && func == FUNC_WRITE)
        begin
            for (int j = 0; j < MAX_DIMS; j++)
            begin
                crd_reg[j] <= crd_in[j];
            end
        end
        if (push)
        begin
            stk_node_reg[sp_reg[$clog2(TREE_LEVELS)-1:0]] <= {node_reg[NODE_W-2:0], 1'b1};
            stk_lo_reg[sp_reg[$clog2(TREE_LEVELS)-1:0]]   <= mid + POS_W'(1);
            stk_hi_reg[sp_reg[$clog2(TREE_LEVELS)-1:0]]   <= hi_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign max_distance = dist_reg;
    assign status       = status_reg;

    // The node RAM is never written while a query walks the tree.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QVISIT || state_reg == S_QACC || state_reg == S_FIN) |-> !ram_we)
        else $error("node RAM written during a query");

    // The traversal stack never grows past the tree depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(TREE_LEVELS))
        else $error("query stack overflow");

    // A result only appears after the output state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output state");

    // A write item never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PWR || state_reg == S_LWR) |=> !$rose(out_valid_reg))
        else $error("result raised by a write item");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Range max Manhattan distance core testbench
// Writes points and queries ranges over several register settings and idling
// patterns. A segment tree model in the bench predicts every query result,
// and a monitor compares each result with the oldest pending expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import rmmd_pkg::*;

    typedef struct {
        logic                          func;
        logic [IDX_W-1:0]              point_index;
        logic [4:0][COORD_WIDTH-1:0]   coords;
        logic [IDX_W-1:0]              range_first;
        logic [IDX_W-1:0]              range_last;
    } cmd_t;

    typedef struct {
        logic [DIST_W-1:0] max_dist;
        logic              status;
    } answer_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic func;
    logic [IDX_W-1:0] point_index;
    logic signed [COORD_WIDTH-1:0] coord_0, coord_1, coord_2, coord_3, coord_4;
    logic [IDX_W-1:0] range_first;
    logic [IDX_W-1:0] range_last;
    logic out_valid;
    logic out_stall;
    logic [DIST_W-1:0] max_distance;
    logic status;

    cmd_t    cmd_q[$];
    answer_t answer_q[$];
    int      errors;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      quiet_cycles;

    longint tree_max[0:NODE_SLOTS-1][0:MASK_SLOTS-1];
    longint tree_min[0:NODE_SLOTS-1][0:MASK_SLOTS-1];
    longint leaf_sum[0:MASK_SLOTS-1];
    longint span_max[0:MASK_SLOTS-1];
    longint span_min[0:MASK_SLOTS-1];
    logic [DIMS_W-1:0] dims_reg;
    logic [IDX_W-1:0]  count_reg;

    range_max_manhattan_distance_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .point_index  (point_index),
        .coord_0      (coord_0),
        .coord_1      (coord_1),
        .coord_2      (coord_2),
        .coord_3      (coord_3),
        .coord_4      (coord_4),
        .range_first  (range_first),
        .range_last   (range_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .max_distance (max_distance),
        .status       (status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int active_dims();
        if (dims_reg == 0)
        begin
            return 1;
        end
        if (dims_reg > MAX_DIMS)
        begin
            return MAX_DIMS;
        end
        return int'(dims_reg);
    endfunction

    function automatic int active_count();
        if (count_reg == 0)
        begin
            return 1;
        end
        if (count_reg > MAX_POINTS)
        begin
            return MAX_POINTS;
        end
        return int'(count_reg);
    endfunction

    function automatic void tree_store(int node, int lo, int hi, int idx, int masks);
        int mid;
        if (node >= NODE_SLOTS)
        begin
            return;
        end
        if (lo == hi)
        begin
            for (int m = 0; m < masks; m++)
            begin
                tree_max[node][m] = leaf_sum[m];
                tree_min[node][m] = leaf_sum[m];
            end
            return;
        end
        mid = (lo + hi) >> 1;
        if (idx <= mid)
        begin
            tree_store(2 * node, lo, mid, idx, masks);
        end
        else
        begin
            tree_store(2 * node + 1, mid + 1, hi, idx, masks);
        end
        if (2 * node + 1 >= NODE_SLOTS)
        begin
            return;
        end
        for (int m = 0; m < masks; m++)
        begin
            tree_max[node][m] = (tree_max[2*node][m] > tree_max[2*node+1][m])
                                ? tree_max[2*node][m] : tree_max[2*node+1][m];
            tree_min[node][m] = (tree_min[2*node][m] < tree_min[2*node+1][m])
                                ? tree_min[2*node][m] : tree_min[2*node+1][m];
        end
    endfunction

    function automatic void tree_gather(int node, int lo, int hi, int qf, int ql, int masks);
        int mid;
        if (node >= NODE_SLOTS)
        begin
            return;
        end
        if (qf <= lo && hi <= ql)
        begin
            for (int m = 0; m < masks; m++)
            begin
                if (tree_max[node][m] > span_max[m])
                begin
                    span_max[m] = tree_max[node][m];
                end
                if (tree_min[node][m] < span_min[m])
                begin
                    span_min[m] = tree_min[node][m];
                end
            end
            return;
        end
        mid = (lo + hi) >> 1;
        if (qf <= mid)
        begin
            tree_gather(2 * node, lo, mid, qf, ql, masks);
        end
        if (ql > mid)
        begin
            tree_gather(2 * node + 1, mid + 1, hi, qf, ql, masks);
        end
    endfunction

    function automatic void apply_cmd(cmd_t c);
        int      dims;
        int      masks;
        int      n;
        longint  s;
        longint  best;
        answer_t a;
        dims  = active_dims();
        masks = 1 << dims;
        n     = active_count();
        if (c.func == FUNC_WRITE)
        begin
            if (c.point_index < 1 || c.point_index > n)
            begin
                return;
            end
            for (int m = 0; m < masks; m++)
            begin
                s = 0;
                for (int j = 0; j < dims; j++)
                begin
                    if (m[j])
                    begin
                        s += longint'($signed(c.coords[j]));
                    end
                    else
                    begin
                        s -= longint'($signed(c.coords[j]));
                    end
                end
                leaf_sum[m] = s;
            end
            tree_store(1, 1, n, int'(c.point_index), masks);
            return;
        end
        if (c.range_first < 1 || c.range_last > n || c.range_first > c.range_last)
        begin
            a.max_dist = '0;
            a.status   = STATUS_BAD;
        end
        else
        begin
            for (int m = 0; m < masks; m++)
            begin
                span_max[m] = 64'sh8000_0000_0000_0000;
                span_min[m] = 64'sh7fff_ffff_ffff_ffff;
            end
            tree_gather(1, 1, n, int'(c.range_first), int'(c.range_last), masks);
            best = 0;
            for (int m = 0; m < masks; m++)
            begin
                if (span_max[m] - span_min[m] > best)
                begin
                    best = span_max[m] - span_min[m];
                end
            end
            if (best > 64'd16777215)
            begin
                best = 64'd16777215;
            end
            a.max_dist = best[DIST_W-1:0];
            a.status   = STATUS_OK;
        end
        answer_q.push_back(a);
    endfunction

    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(5))
            0: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
            1: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
            2: return COORD_WIDTH'($urandom_range(15)) - COORD_WIDTH'(8);
            default: return COORD_WIDTH'($urandom);
        endcase
    endfunction

    function automatic cmd_t make_write(int idx, logic [4:0][COORD_WIDTH-1:0] c);
        cmd_t x;
        x.func        = FUNC_WRITE;
        x.point_index = IDX_W'(idx);
        x.coords      = c;
        x.range_first = IDX_W'($urandom);
        x.range_last  = IDX_W'($urandom);
        return x;
    endfunction

    function automatic cmd_t make_query(int qf, int ql);
        cmd_t x;
        x.func        = FUNC_QUERY;
        x.point_index = IDX_W'($urandom);
        for (int j = 0; j < 5; j++)
        begin
            x.coords[j] = COORD_WIDTH'($urandom);
        end
        x.range_first = IDX_W'(qf);
        x.range_last  = IDX_W'(ql);
        return x;
    endfunction

    function automatic cmd_t random_cmd(int n);
        logic [4:0][COORD_WIDTH-1:0] c;
        int idx;
        int qf;
        int ql;
        for (int j = 0; j < 5; j++)
        begin
            c[j] = rand_coord();
        end
        if ($urandom_range(1) == 0)
        begin
            idx = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(n, 1);
            return make_write(idx, c);
        end
        case ($urandom_range(9))
            0: return make_query($urandom_range(2047), $urandom_range(2047));
            1: return make_query(0, $urandom_range(n));
            2:
            begin
                qf = $urandom_range(n, 1);
                return make_query(qf, $urandom_range(2047, n + 1));
            end
            3:
            begin
                qf = $urandom_range(n, 1);
                return make_query(qf, qf);
            end
            default:
            begin
                qf = $urandom_range(n, 1);
                ql = $urandom_range(n, qf);
                return make_query(qf, ql);
            end
        endcase
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        dims_reg  = (idx == REG_DIMS) ? DIMS_W'(value) : dims_reg;
        count_reg = (idx == REG_COUNT) ? IDX_W'(value) : count_reg;
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || answer_q.size() != 0 || in_valid)
        begin
            @(negedge clk);
        end
        repeat (300) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            apply_cmd(cmd_q[0]);
            cmd_q.pop_front();
        end
        if (!(in_valid && in_stall))
        begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid    <= 1'b1;
                func        <= cmd_q[0].func;
                point_index <= cmd_q[0].point_index;
                coord_0     <= cmd_q[0].coords[0];
                coord_1     <= cmd_q[0].coords[1];
                coord_2     <= cmd_q[0].coords[2];
                coord_3     <= cmd_q[0].coords[3];
                coord_4     <= cmd_q[0].coords[4];
                range_first <= cmd_q[0].range_first;
                range_last  <= cmd_q[0].range_last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (answer_q.size() == 0)
            begin
                report("unexpected result", 32'(max_distance), 0);
            end
            else
            begin
                if (max_distance !== answer_q[0].max_dist)
                begin
                    report("max_distance", 32'(max_distance), 32'(answer_q[0].max_dist));
                end
                if (status !== answer_q[0].status)
                begin
                    report("status", 32'(status), 32'(answer_q[0].status));
                end
                answer_q.pop_front();
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= 20000)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int dims_set[8];
        int count_set[8];
        int idle_set[4];
        int stall_set[4];
        logic [4:0][COORD_WIDTH-1:0] c;
        dims_set  = '{5, 1, 3, 2, 0, 7, 4, 5};
        count_set = '{1024, 1, 7, 2, 0, 2047, 100, 1024};
        idle_set  = '{0, 55, 0, 22};
        stall_set = '{0, 0, 55, 22};
        errors = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        dims_reg = 3'd5;
        count_reg = 11'd1024;
        for (int i = 0; i < NODE_SLOTS; i++)
        begin
            for (int m = 0; m < MASK_SLOTS; m++)
            begin
                tree_max[i][m] = 0;
                tree_min[i][m] = 0;
            end
        end
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        func = FUNC_WRITE;
        point_index = '0;
        coord_0 = '0;
        coord_1 = '0;
        coord_2 = '0;
        coord_3 = '0;
        coord_4 = '0;
        range_first = '0;
        range_last = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (in_stall)
        begin
            @(negedge clk);
        end

        // Directed items with the reset register values.
        cmd_q.push_back(make_query(1, 1024));
        for (int j = 0; j < 5; j++)
        begin
            c[j] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        cmd_q.push_back(make_write(1, c));
        for (int j = 0; j < 5; j++)
        begin
            c[j] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        cmd_q.push_back(make_write(1024, c));
        cmd_q.push_back(make_write(0, c));
        cmd_q.push_back(make_write(1025, c));
        cmd_q.push_back(make_write(2047, c));
        cmd_q.push_back(make_query(1, 1024));
        cmd_q.push_back(make_query(1, 1));
        cmd_q.push_back(make_query(1024, 1024));
        cmd_q.push_back(make_query(2, 1023));
        cmd_q.push_back(make_query(0, 5));
        cmd_q.push_back(make_query(3, 1025));
        cmd_q.push_back(make_query(9, 8));
        cmd_q.push_back(make_query(2047, 2047));
        for (int j = 0; j < 5; j++)
        begin
            c[j] = (j % 2 == 0) ? COORD_WIDTH'(-1) : COORD_WIDTH'(1);
        end
        cmd_q.push_back(make_write(512, c));
        cmd_q.push_back(make_query(500, 1024));
        cmd_q.push_back(make_query(1, 512));
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_DIMS, dims_set[p]);
            write_reg(REG_COUNT, count_set[p]);
            send_idle_pct  = idle_set[p % 4];
            recv_stall_pct = stall_set[p % 4];
            @(negedge clk);
            for (int i = 0; i < 64; i++)
            begin
                cmd_q.push_back(random_cmd(active_count()));
            end
            wait_drained();
        end

        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
